[design/bac_pkg.sv]
// Package for the buddy allocator: command/status codes, controller-datapath structs.
// No dependencies.
`default_nettype none
package bac_pkg;
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_PIN   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOBLOCK = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    localparam logic [5:0] FREE_BIAS = 6'd32;

    // heap unit is two objects; unit size must stay a power of two
    localparam int OBJECT_BYTES = 4;
    localparam int UNIT_BYTES   = 2 * OBJECT_BYTES;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE     = 5'd0,
        OP_LOAD     = 5'd1,   // latch item, compute order/unit
        OP_SCAN     = 5'd2,   // look at head[k], advance k
        OP_POP_RD   = 5'd3,   // read link[b]
        OP_POP_WR   = 5'd4,   // head[k]=link, link[b]=end
        OP_SPLIT    = 5'd5,   // push upper half, j--
        OP_MARK_A   = 5'd6,   // mark allocated start
        OP_FMARK_RD = 5'd7,   // read mark[unit]
        OP_FCHECK   = 5'd8,   // check mark, set j
        OP_BUD_RD   = 5'd9,   // read mark[buddy]
        OP_BUD_CHK  = 5'd10,  // compare buddy mark
        OP_WALK_RD  = 5'd11,  // read link[cur]
        OP_WALK_ADV = 5'd12,  // compare / advance
        OP_UNLINK   = 5'd13,  // splice out
        OP_MERGE    = 5'd14,  // clear marks, unit=min, j++
        OP_PUSH_F   = 5'd15,  // push final block
        OP_PIN      = 5'd16,  // clear mark
        OP_INIT     = 5'd17,  // reset sweep step
        OP_DONE_OK  = 5'd18,
        OP_DONE_BAD = 5'd19
    } t_op;

    typedef struct packed {
        logic        is_alloc;
        logic        is_free;
        logic        is_pin;
        logic        size_bad;   // zero or oversize, or address bad, or command unknown
        logic        k_over;     // scan past top order
        logic        head_empty; // head[k] empty
        logic        split_more; // j > order
        logic        mark_ok;    // free check passes
        logic        top_order;  // j >= MAX_ORDER
        logic        buddy_free; // buddy marked free at j
        logic        walk_end;   // walk stopped without match
        logic        walk_hit;   // cur == target
        logic        init_done;
        logic [1:0]  fail_status;
    } t_status;
endpackage
`default_nettype wire

[design/buddy_allocator_checked_free.sv]
// Buddy allocator with checked free: command interface, one result per item.
// Sequence of operation: the block clears its mark and link memories after
// reset (busy high), then accepts an item when start is high and busy is low.
// Commands: allocate (size in i_request_bytes), free and pin (byte offset in
// i_block_address).
// Each item yields exactly one result, shown on o_result_address/o_status for
// one cycle with o_done high; the receiver cannot stall.
// The result follows the last busy cycle in the next cycle, with busy already
// low, so a new item can be accepted at the edge that takes the result.
// Allocate time grows with the empty orders skipped and the split levels;
// free time grows with the merge levels and the free-list nodes walked (the
// matching node included).
// The free-list walk through the link memory dominates.
// Reset (i_rst_n low, synchronous) returns the heap to one free top block.
// Depends on bac_pkg, bac_ctrl, bac_datapath.
`default_nettype none
module buddy_allocator_checked_free
    import bac_pkg::*;
#(
    parameter int UNIT_COUNT   = 1024,
    parameter int MAX_ORDER    = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_request_bytes,
    input  wire logic [12:0] i_block_address,
    output logic             o_done,
    output logic [12:0]      o_result_address,
    output logic [1:0]       o_status
);
    t_op     op;
    t_status st;

    bac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_st    (st),
        .o_op    (op)
    );

    bac_datapath #(
        .UNIT_COUNT   (UNIT_COUNT),
        .MAX_ORDER    (MAX_ORDER)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_command        (i_command),
        .i_request_bytes  (i_request_bytes),
        .i_block_address  (i_block_address),
        .o_st             (st),
        .o_valid          (o_done),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

    a_addr_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_result_address == '0)
        else $error("nonzero address with failing status");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status != 2'd3)
        else $error("bad status code");
endmodule
`default_nettype wire

[design/bac_ctrl.sv]
// Controller state machine for the buddy allocator.
// Uses bac_pkg; drives bac_datapath with one operation per cycle.
`default_nettype none
module bac_ctrl
    import bac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  t_status      i_st,
    output t_op          o_op
);
    typedef enum logic [16:0] {
        S_INIT    = 17'h00001,
        S_IDLE    = 17'h00002,
        S_DECODE  = 17'h00004,
        S_SCAN    = 17'h00008,
        S_POP_RD  = 17'h00010,
        S_POP_WR  = 17'h00020,
        S_SPLIT   = 17'h00040,
        S_MARK_A  = 17'h00080,
        S_FRD     = 17'h00100,
        S_FCHK    = 17'h00200,
        S_BRD     = 17'h00400,
        S_BCHK    = 17'h00800,
        S_WRD     = 17'h01000,
        S_WADV    = 17'h02000,
        S_UNLINK  = 17'h04000,
        S_MERGE   = 17'h08000,
        S_FIN     = 17'h10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_INIT: begin
                o_op = OP_INIT;
                if (i_st.init_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.size_bad) begin
                    o_op = OP_DONE_BAD;
                    n_state = S_IDLE;
                end else if (i_st.is_alloc) begin
                    n_state = S_SCAN;
                end else if (i_st.is_free) begin
                    o_op = OP_FMARK_RD;
                    n_state = S_FRD;
                end else begin
                    o_op = OP_PIN;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_st.k_over) begin
                    o_op = OP_DONE_BAD;
                    n_state = S_IDLE;
                end else begin
                    o_op = OP_SCAN;
                    if (!i_st.head_empty) n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                o_op = OP_POP_RD;
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                o_op = OP_POP_WR;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_st.split_more) begin
                    o_op = OP_SPLIT;
                end else begin
                    o_op = OP_MARK_A;
                    n_state = S_IDLE;
                end
            end
            S_MARK_A: n_state = S_IDLE;
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (i_st.mark_ok) begin
                    o_op = OP_FCHECK;
                    n_state = S_BRD;
                end else begin
                    o_op = OP_DONE_BAD;
                    n_state = S_IDLE;
                end
            end
            S_BRD: begin
                if (i_st.top_order) begin
                    n_state = S_FIN;
                end else begin
                    o_op = OP_BUD_RD;
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                if (i_st.buddy_free) begin
                    o_op = OP_BUD_CHK;
                    n_state = S_WRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WRD: begin
                if (i_st.walk_end) begin
                    n_state = S_MERGE;
                end else begin
                    o_op = OP_WALK_RD;
                    n_state = S_WADV;
                end
            end
            S_WADV: begin
                if (i_st.walk_hit) begin
                    n_state = S_UNLINK;
                end else begin
                    o_op = OP_WALK_ADV;
                    n_state = S_WRD;
                end
            end
            S_UNLINK: begin
                o_op = OP_UNLINK;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                o_op = OP_MERGE;
                n_state = S_BRD;
            end
            S_FIN: begin
                o_op = OP_PUSH_F;
                n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end
endmodule
`default_nettype wire

[design/bac_datapath.sv]
// Datapath for the buddy allocator: mark, link and head memories plus working registers.
// Uses bac_pkg; sequenced by bac_ctrl.
`default_nettype none
module bac_datapath
    import bac_pkg::*;
#(
    parameter int UNIT_COUNT   = 1024,
    parameter int MAX_ORDER    = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_op              i_op,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_request_bytes,
    input  wire logic [12:0] i_block_address,
    output t_status          o_st,
    output logic             o_valid,
    output logic [12:0]      o_result_address,
    output logic [1:0]       o_status
);
    localparam int UW = $clog2(UNIT_COUNT);        // unit index width
    localparam int LW = UW + 1;                    // link value incl. end mark
    localparam int OW = $clog2(MAX_ORDER + 2);     // order counter, holds MAX_ORDER+1
    localparam longint HEAP_BYTES = longint'(UNIT_COUNT) * UNIT_BYTES;
    localparam logic [LW-1:0] END_MARK = LW'(UNIT_COUNT);
    localparam int HW = $clog2(MAX_ORDER + 1) > 0 ? $clog2(MAX_ORDER + 1) : 1;

    // memories
    logic [5:0]    mark_mem [UNIT_COUNT];
    logic [LW-1:0] link_mem [UNIT_COUNT];
    logic [LW-1:0] head_r   [MAX_ORDER + 1];

    logic          r_mk_we;  logic [UW-1:0] r_mk_wa; logic [5:0] r_mk_wd;
    logic [5:0]    r_mk_q;
    logic [LW-1:0] r_ln_q;

    logic          mk_we, ln_we, mk_re, ln_re;
    logic [UW-1:0] mk_a, ln_a, mk_ra, ln_ra;
    logic [5:0]    mk_d;
    logic [LW-1:0] ln_d;

    // deferred clear from a merge lands in a cycle with no other mark write
    always_ff @(posedge i_clk) begin
        if (mk_we) mark_mem[mk_a] <= mk_d;
        else if (r_mk_we) mark_mem[r_mk_wa] <= r_mk_wd;
        if (mk_re) r_mk_q <= mark_mem[mk_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ln_we) link_mem[ln_a] <= ln_d;
        if (ln_re) r_ln_q <= link_mem[ln_ra];
    end

    // working registers
    logic [1:0]    r_cmd;
    logic [OW-1:0] r_order, r_k, r_j;
    logic [UW-1:0] r_unit, r_b;
    logic          r_bad;
    logic [LW-1:0] r_cur, r_prev;
    logic [LW:0]   r_steps;
    logic [UW:0]   r_init;
    logic          r_valid;
    logic [12:0]   r_res;
    logic [1:0]    r_stat;

    // order of request: smallest k with 2^k*UNIT_BYTES >= size
    logic [OW-1:0] req_order;
    logic          req_over;
    always_comb begin
        req_order = '0;
        req_over  = 1'b1;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if (longint'(i_request_bytes) <= (longint'(UNIT_BYTES) << k)) begin
                req_order = OW'(k);
                req_over  = 1'b0;
            end
        end
    end
    logic addr_ok;
    assign addr_ok = (longint'(i_block_address) % UNIT_BYTES == 0) &&
                     (longint'(i_block_address) < HEAP_BYTES);
    logic [UW-1:0] addr_unit;
    assign addr_unit = UW'(longint'(i_block_address) / UNIT_BYTES);

    logic [HW-1:0] k_i, j_i;
    assign k_i = HW'(r_k);
    assign j_i = HW'(r_j);
    logic [UW-1:0] buddy, upper;
    assign buddy = r_unit ^ (UW'(1) << r_j);
    assign upper = r_b + (UW'(1) << (r_j - OW'(1)));
    logic [LW-1:0] head_k;
    assign head_k = head_r[k_i];

    always_comb begin
        mk_we = 1'b0; mk_a = r_unit; mk_d = '0;
        ln_we = 1'b0; ln_a = r_b;    ln_d = END_MARK;
        mk_re = 1'b0; mk_ra = r_unit;
        ln_re = 1'b0; ln_ra = r_b;
        unique case (i_op)
            OP_INIT: begin
                mk_we = 1'b1; mk_a = r_init[UW-1:0];
                mk_d  = (r_init == '0) ? 6'(MAX_ORDER) + FREE_BIAS : 6'd0;
                ln_we = 1'b1; ln_a = r_init[UW-1:0]; ln_d = END_MARK;
            end
            OP_POP_RD:   ln_re = 1'b1;
            OP_POP_WR:   ln_we = 1'b1;
            OP_SPLIT: begin
                mk_we = 1'b1; mk_a = upper; mk_d = 6'(r_j - OW'(1)) + FREE_BIAS;
                ln_we = 1'b1; ln_a = upper; ln_d = head_r[HW'(r_j - OW'(1))];
            end
            OP_MARK_A: begin
                mk_we = 1'b1; mk_a = r_b; mk_d = 6'(r_order) + 6'd1;
            end
            OP_FMARK_RD: begin
                mk_re = 1'b1; mk_ra = r_unit;
            end
            OP_BUD_RD: begin
                mk_re = 1'b1; mk_ra = buddy;
            end
            OP_WALK_RD: begin
                ln_re = 1'b1; ln_ra = r_cur[UW-1:0];
            end
            OP_WALK_ADV: ;
            OP_UNLINK: begin
                if (r_prev != END_MARK) begin
                    ln_we = 1'b1; ln_a = r_prev[UW-1:0]; ln_d = r_ln_q;
                end
            end
            OP_MERGE: begin
                mk_we = 1'b1; mk_a = buddy; mk_d = '0;
            end
            OP_PUSH_F: begin
                mk_we = 1'b1; mk_a = r_unit; mk_d = 6'(r_j) + FREE_BIAS;
                ln_we = 1'b1; ln_a = r_unit; ln_d = head_r[j_i];
            end
            OP_PIN: begin
                mk_we = 1'b1; mk_a = r_unit; mk_d = '0;
            end
            default: ;
        endcase
    end

    // merge clears the old unit mark too; the final push overwrites the survivor,
    // so only the higher of the pair needs clearing: do it via r_mk_we next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mk_we <= 1'b0;
        end else begin
            r_mk_we <= 1'b0;
            if (i_op == OP_MERGE) begin
                r_mk_we <= 1'b1;
                r_mk_wa <= r_unit;
            end
        end
        r_mk_wd <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i <= MAX_ORDER; i++)
                head_r[i] <= (i == MAX_ORDER) ? LW'(0) : END_MARK;
        end else begin
            r_valid <= 1'b0;
            unique case (i_op)
                OP_INIT: r_init <= r_init + 1'b1;
                OP_LOAD: begin
                    r_cmd   <= i_command;
                    r_order <= req_order;
                    r_k     <= req_order;
                    r_unit  <= addr_unit;
                    r_bad   <= (i_command == CMD_ALLOC) ?
                               (i_request_bytes == '0 || req_over) :
                               (i_command == CMD_FREE || i_command == CMD_PIN) ?
                               !addr_ok : 1'b1;
                end
                OP_SCAN: begin
                    if (head_k[LW-1:UW] == '0) r_b <= head_k[UW-1:0];
                    else r_k <= r_k + OW'(1);
                    r_j <= r_k;
                end
                OP_POP_WR: head_r[k_i] <= r_ln_q;
                OP_SPLIT: begin
                    head_r[HW'(r_j - OW'(1))] <= LW'(upper);
                    r_j <= r_j - OW'(1);
                end
                OP_MARK_A: begin
                    r_valid <= 1'b1;
                    r_res   <= 13'(longint'(r_b) * UNIT_BYTES);
                    r_stat  <= ST_OK;
                end
                OP_FCHECK: r_j <= OW'(r_mk_q - 6'd1);
                OP_BUD_CHK: begin
                    r_cur   <= head_r[j_i];
                    r_prev  <= END_MARK;
                    r_steps <= '0;
                end
                OP_WALK_ADV: begin
                    r_prev  <= r_cur;
                    r_cur   <= r_ln_q;
                    r_steps <= r_steps + 1'b1;
                end
                OP_UNLINK: if (r_prev == END_MARK) head_r[j_i] <= r_ln_q;
                OP_MERGE: begin
                    if (buddy < r_unit) r_unit <= buddy;
                    r_j <= r_j + OW'(1);
                end
                OP_PUSH_F: begin
                    head_r[j_i] <= LW'(r_unit);
                    r_valid <= 1'b1; r_res <= '0; r_stat <= ST_OK;
                end
                OP_PIN: begin
                    r_valid <= 1'b1; r_res <= '0; r_stat <= ST_OK;
                end
                OP_DONE_BAD: begin
                    r_valid <= 1'b1; r_res <= '0;
                    r_stat  <= (r_cmd == CMD_ALLOC) ? ST_NOBLOCK : ST_ILLEGAL;
                end
                default: ;
            endcase
        end
    end

    // walk_rd reads link[cur] into r_ln_q; compare uses r_cur
    logic walk_stop;
    assign walk_stop = (r_cur[LW-1:UW] != '0) || (r_steps >= (LW+1)'(UNIT_COUNT));

    always_comb begin
        o_st = '0;
        o_st.is_alloc    = (r_cmd == CMD_ALLOC);
        o_st.is_free     = (r_cmd == CMD_FREE);
        o_st.is_pin      = (r_cmd == CMD_PIN);
        o_st.size_bad    = r_bad;
        o_st.k_over      = (r_k > OW'(MAX_ORDER));
        o_st.head_empty  = (head_k[LW-1:UW] != '0);
        o_st.split_more  = (r_j > r_order);
        o_st.mark_ok     = (r_mk_q != '0) && (r_mk_q < FREE_BIAS) &&
                           ({2'b0, r_mk_q} - 8'd1 <= 8'(MAX_ORDER));
        o_st.top_order   = (r_j >= OW'(MAX_ORDER));
        o_st.buddy_free  = (r_mk_q == 6'(r_j) + FREE_BIAS);
        o_st.walk_end    = walk_stop;
        o_st.walk_hit    = (r_cur == LW'(buddy));
        o_st.init_done   = (r_init == (UW+1)'(UNIT_COUNT - 1));
        o_st.fail_status = (r_cmd == CMD_ALLOC) ? ST_NOBLOCK : ST_ILLEGAL;
    end

    assign o_valid          = r_valid;
    assign o_result_address = r_res;
    assign o_status         = r_stat;
endmodule
`default_nettype wire
